### sv/tsvfi_pkg.sv
package tsvfi_pkg;

  // Field and line terminators
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_PAD
  } tsvfi_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_a;
    logic load_b;
    logic load_pad;
    logic last;
  } tsvfi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_a;
    logic has_b;
    logic has_pad;
    logic b_pend;
    logic pad_more;
    logic pad_last;
  } tsvfi_sts_t;

endpackage

### sv/tsvfi_ctrl.sv
module tsvfi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tsvfi_pkg::tsvfi_sts_t sts,
  output tsvfi_pkg::tsvfi_cmd_t cmd
);
  import tsvfi_pkg::*;

  tsvfi_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (sts.has_a) state_nxt = ST_EMIT_A;
          else if (sts.has_b)     state_nxt = ST_EMIT_B;
          else if (sts.has_pad)   state_nxt = ST_PAD;
          else                    state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_A: begin
        if (out_free) begin
          cmd.load_a = 1'b1;
          cmd.last   = !sts.b_pend && !sts.pad_more;
          priority if (sts.b_pend) state_nxt = ST_EMIT_B;
          else if (sts.pad_more)   state_nxt = ST_PAD;
          else                     state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_B: begin
        if (out_free) begin
          cmd.load_b = 1'b1;
          cmd.last   = !sts.pad_more;
          state_nxt  = sts.pad_more ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          cmd.load_pad = 1'b1;
          cmd.last     = sts.pad_last;
          state_nxt    = sts.pad_last ? ST_IDLE : ST_PAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_a || cmd.load_b || cmd.load_pad) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/tsvfi_datapath.sv
module tsvfi_datapath #(
  parameter int MAX_COLUMNS = 64,
  parameter int OFFSET_BITS = 24,
  parameter int ROW_BITS    = 16,
  localparam int COL_BITS   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int WID_BITS   = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_file,
  input  tsvfi_pkg::tsvfi_cmd_t  cmd,
  output tsvfi_pkg::tsvfi_sts_t  sts,
  output logic [ROW_BITS-1:0]    out_row_index,
  output logic [COL_BITS-1:0]    out_column_index,
  output logic [OFFSET_BITS-1:0] out_field_offset,
  output logic [OFFSET_BITS-1:0] out_field_length,
  output logic                   out_last_of_run
);
  import tsvfi_pkg::*;

  localparam logic [WID_BITS-1:0] MaxCols = WID_BITS'(MAX_COLUMNS);

  // Scan state
  logic                   hdr_r, hdr_nxt;
  logic [WID_BITS-1:0]    width_r, width_nxt;
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] fstart_r, fstart_nxt;
  logic [OFFSET_BITS-1:0] fbytes_r, fbytes_nxt;
  logic                   after_cr_r, after_cr_nxt;
  logic                   ovf_r, ovf_nxt;

  // Job held for the entries of one word
  logic [ROW_BITS-1:0]    job_row_r;
  logic [COL_BITS-1:0]    a_col_r, b_col_r;
  logic [OFFSET_BITS-1:0] a_off_r, a_len_r, b_off_r, b_len_r, pad_off_r;
  logic                   b_pend_r, pad_en_r;
  logic [WID_BITS-1:0]    pad_k_r, pad_end_r;

  // Output word
  logic [ROW_BITS-1:0]    o_row_r;
  logic [COL_BITS-1:0]    o_col_r;
  logic [OFFSET_BITS-1:0] o_off_r, o_len_r;
  logic                   o_last_r;

  // Per-word decode
  logic                   is_tab, is_cr, is_lf, lf_after, term, eol, line_ended;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [WID_BITS-1:0]    col_inc, limit, pad_start, pad_end;
  logic                   tab_ok, pad_en, has_b;
  logic                   hdr1, ovf1, after_cr1;
  logic [WID_BITS-1:0]    width1;
  logic [COL_BITS-1:0]    col1;
  logic [ROW_BITS-1:0]    row1;
  logic [OFFSET_BITS-1:0] fstart1, fbytes1;

  always_comb begin
    is_tab   = (in_data_byte == CHAR_TAB);
    is_cr    = (in_data_byte == CHAR_CR);
    is_lf    = (in_data_byte == CHAR_LF);
    lf_after = after_cr_r && is_lf;
    term     = !lf_after && (is_tab || is_cr || is_lf);
    eol      = term && !is_tab;
    pos_inc  = (&pos_r) ? pos_r : pos_r + 1'b1;
    col_inc  = WID_BITS'(col_r) + 1'b1;
    limit    = hdr_r ? width_r : MaxCols;
    tab_ok   = !ovf_r && (col_inc < limit);

    hdr1      = hdr_r;
    width1    = width_r;
    col1      = col_r;
    row1      = row_r;
    ovf1      = ovf_r;
    fstart1   = fstart_r;
    fbytes1   = fbytes_r;
    after_cr1 = 1'b0;

    priority if (lf_after) begin
      // second half of CR LF: line already closed
      fstart1 = pos_inc;
    end else if (term) begin
      fstart1 = pos_inc;
      fbytes1 = '0;
      if (is_tab) begin
        if (tab_ok) begin
          col1 = COL_BITS'(col_inc);
          if (!hdr_r) width1 = col_inc + 1'b1;
        end else begin
          ovf1 = 1'b1;
        end
      end else begin
        row1      = (&row_r) ? row_r : row_r + 1'b1;
        col1      = '0;
        ovf1      = 1'b0;
        hdr1      = 1'b1;
        after_cr1 = is_cr;
      end
    end else if (!(&fbytes_r)) begin
      fbytes1 = fbytes_r + 1'b1;
    end

    line_ended = lf_after || eol;
    has_b      = in_end_of_file && !line_ended && !ovf1;

    priority if (eol) begin
      pad_en    = !ovf_r;
      pad_start = col_inc;
      pad_end   = width_r;
    end else if (in_end_of_file && !line_ended) begin
      pad_en    = !ovf1;
      pad_start = WID_BITS'(col1) + 1'b1;
      pad_end   = width1;
    end else begin
      pad_en    = 1'b0;
      pad_start = col_inc;
      pad_end   = width_r;
    end

    // end of file: back to the reset state
    if (in_end_of_file) begin
      hdr_nxt      = 1'b0;
      width_nxt    = WID_BITS'(1);
      col_nxt      = '0;
      row_nxt      = '0;
      pos_nxt      = '0;
      fstart_nxt   = '0;
      fbytes_nxt   = '0;
      after_cr_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end else begin
      hdr_nxt      = hdr1;
      width_nxt    = width1;
      col_nxt      = col1;
      row_nxt      = row1;
      pos_nxt      = pos_inc;
      fstart_nxt   = fstart1;
      fbytes_nxt   = fbytes1;
      after_cr_nxt = after_cr1;
      ovf_nxt      = ovf1;
    end

    sts.has_a    = term && !ovf_r;
    sts.has_b    = has_b;
    sts.has_pad  = pad_en && (pad_start < pad_end);
    sts.b_pend   = b_pend_r;
    sts.pad_more = pad_en_r && (pad_k_r < pad_end_r);
    sts.pad_last = ((pad_k_r + 1'b1) >= pad_end_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= 1'b0;
      width_r    <= WID_BITS'(1);
      col_r      <= '0;
      row_r      <= '0;
      pos_r      <= '0;
      fstart_r   <= '0;
      fbytes_r   <= '0;
      after_cr_r <= 1'b0;
      ovf_r      <= 1'b0;
      b_pend_r   <= 1'b0;
      pad_en_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        hdr_r      <= hdr_nxt;
        width_r    <= width_nxt;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        pos_r      <= pos_nxt;
        fstart_r   <= fstart_nxt;
        fbytes_r   <= fbytes_nxt;
        after_cr_r <= after_cr_nxt;
        ovf_r      <= ovf_nxt;
        b_pend_r   <= has_b;
        pad_en_r   <= pad_en;
      end else if (cmd.load_b) begin
        b_pend_r <= 1'b0;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      job_row_r <= row_r;
      a_col_r   <= col_r;
      a_off_r   <= fstart_r;
      a_len_r   <= fbytes_r;
      b_col_r   <= col1;
      b_off_r   <= fstart1;
      b_len_r   <= fbytes1;
      pad_k_r   <= pad_start;
      pad_end_r <= pad_end;
      pad_off_r <= pos_inc;
    end else if (cmd.load_pad) begin
      pad_k_r <= pad_k_r + 1'b1;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.load_a || cmd.load_b || cmd.load_pad) begin
      o_row_r  <= job_row_r;
      o_last_r <= cmd.last;
    end
    priority if (cmd.load_a) begin
      o_col_r <= a_col_r;
      o_off_r <= a_off_r;
      o_len_r <= a_len_r;
    end else if (cmd.load_b) begin
      o_col_r <= b_col_r;
      o_off_r <= b_off_r;
      o_len_r <= b_len_r;
    end else if (cmd.load_pad) begin
      o_col_r <= COL_BITS'(pad_k_r);
      o_off_r <= pad_off_r;
      o_len_r <= '0;
    end
  end

  assign out_row_index    = o_row_r;
  assign out_column_index = o_col_r;
  assign out_field_offset = o_off_r;
  assign out_field_length = o_len_r;
  assign out_last_of_run  = o_last_r;

endmodule

### sv/tsv_field_indexer_top.sv
// Cell indexer for tab-separated text.
// Input channel (in_valid/in_ready): one word per file byte, in_data_byte plus
// in_end_of_file on the final byte. Output channel (out_valid/out_ready): one
// word per cell entry (row, column, offset, length); out_last_of_run marks the
// final entry caused by the current input byte.
// Each input byte is accepted in ST_IDLE, then the sequencer loads each entry
// it causes in turn: the entry of the field that a terminator or end of file
// closes (none once the row has overflowed), and at a short line end one pad
// entry per missing column up to the table width. The next byte is accepted
// only once the last entry of the current one is loaded into the single
// output register, which the pad sequencer fills from the job latch.
// A stall on out_ready holds the output word and the sequencer; input waits.
// End of file returns the scan state to its reset values so a new file can
// follow at offset 0. Reset (rst_n low, synchronous) clears the scan state,
// drops any pending entries and empties the output register.
module tsv_field_indexer_top #(
  parameter int MAX_COLUMNS = 64,
  parameter int OFFSET_BITS = 24,
  parameter int ROW_BITS    = 16,
  localparam int COL_BITS   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_file,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROW_BITS-1:0]    out_row_index,
  output logic [COL_BITS-1:0]    out_column_index,
  output logic [OFFSET_BITS-1:0] out_field_offset,
  output logic [OFFSET_BITS-1:0] out_field_length,
  output logic                   out_last_of_run
);
  import tsvfi_pkg::*;

  tsvfi_cmd_t cmd;
  tsvfi_sts_t sts;

  // Sequencer: accepts a word, then walks field and pad entries.
  tsvfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Scan state, job latch and output register.
  tsvfi_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .OFFSET_BITS (OFFSET_BITS),
    .ROW_BITS    (ROW_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .cmd              (cmd),
    .sts              (sts),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_field_offset (out_field_offset),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run)
  );

`ifndef SYNTHESIS
  // Idle only with no entry left in the job.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!sts.b_pend && !sts.pad_more))
    else $error("sequencer idle with entries pending");

  // One entry source per cycle.
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_a, cmd.load_b, cmd.load_pad}))
    else $error("more than one entry loaded at once");

  // Loading the last entry of a run frees the input side.
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.load_a || cmd.load_b || cmd.load_pad) && cmd.last) |=> in_ready)
    else $error("input not reopened after last entry");

  // Never accept while a job is still draining.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.load_a || cmd.load_b || cmd.load_pad))
    else $error("accept overlaps entry load");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tsvfi_pkg::*;

  localparam int ROW_W = 16;
  localparam int COL_W = 6;
  localparam int OFF_W = 24;
  localparam int MAX_COLS = 64;
  localparam int unsigned OFF_TOP = (32'd1 << OFF_W) - 1;
  localparam int unsigned ROW_TOP = (32'd1 << ROW_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // One cell entry as it leaves the block
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] len;
    logic             last;
  } cell_t;

  // Scan state of the indexer, the cell entries it should produce, and the check
  // of what the block actually sends out.
  class cell_scoreboard;
    bit          hdr_seen;
    bit          cr_pending;
    bit          dropping;
    int unsigned width_now;
    int unsigned col_now;
    int unsigned row_now;
    int unsigned pos_now;
    int unsigned start_now;
    int unsigned len_now;
    cell_t       cells_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned bytes_seen;

    function new();
      rewind();
      errors = 0;
      checked = 0;
      bytes_seen = 0;
    endfunction

    // Return to the start of a new file
    function void rewind();
      hdr_seen = 0;
      cr_pending = 0;
      dropping = 0;
      width_now = 1;
      col_now = 0;
      row_now = 0;
      pos_now = 0;
      start_now = 0;
      len_now = 0;
    endfunction

    function void add_cell(int unsigned col, int unsigned off, int unsigned len);
      cell_t c;
      c.row = row_now[ROW_W-1:0];
      c.col = col[COL_W-1:0];
      c.off = off[OFF_W-1:0];
      c.len = len[OFF_W-1:0];
      c.last = 1'b0;
      cells_due.push_back(c);
    endfunction

    // Pad a short row out to the table width, then advance to the next row
    function void close_line(int unsigned pad_off);
      if (!dropping)
        for (int unsigned k = col_now + 1; k < width_now; k++) add_cell(k, pad_off, 0);
      if (row_now < ROW_TOP) row_now++;
      col_now = 0;
      dropping = 0;
      hdr_seen = 1;
    endfunction

    // Index one accepted byte: queue the cell entries it closes
    function void note_byte(logic [7:0] b, logic eof);
      int unsigned nxt;
      int unsigned lim;
      int          first;
      bit          ended;
      cell_t       c;
      nxt = (pos_now < OFF_TOP) ? pos_now + 1 : OFF_TOP;
      first = cells_due.size();
      ended = 0;
      bytes_seen++;
      if (cr_pending && b == CHAR_LF) begin
        // second half of CR LF: no entry
        cr_pending = 0;
        start_now = nxt;
        ended = 1;
      end else begin
        cr_pending = 0;
        if (b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF) begin
          if (!dropping) add_cell(col_now, start_now, len_now);
          if (b == CHAR_TAB) begin
            lim = hdr_seen ? width_now : MAX_COLS;
            if (!dropping && col_now + 1 < lim) begin
              col_now++;
              if (!hdr_seen) width_now = col_now + 1;
            end else begin
              dropping = 1;
            end
          end else begin
            close_line(nxt);
            cr_pending = (b == CHAR_CR);
            ended = 1;
          end
          start_now = nxt;
          len_now = 0;
        end else if (len_now < OFF_TOP) begin
          len_now++;
        end
      end
      pos_now = nxt;
      if (eof) begin
        // close the open field and line unless a terminator just did
        if (!ended) begin
          if (!dropping) add_cell(col_now, start_now, len_now);
          close_line(nxt);
        end
        rewind();
      end
      if (cells_due.size() > first) begin
        c = cells_due.pop_back();
        c.last = 1'b1;
        cells_due.push_back(c);
      end
    endfunction

    // Compare one cell entry from the block with the oldest one due
    function void check_entry(cell_t got);
      cell_t want;
      if (cells_due.size() == 0) begin
        errors++;
        $error("cell entry with none due: row %0d column %0d offset %0d length %0d",
               got.row, got.col, got.off, got.len);
        return;
      end
      want = cells_due.pop_front();
      checked++;
      if (got.row != want.row) begin
        errors++;
        $error("row_index: expected %0d, actual %0d", want.row, got.row);
      end
      if (got.col != want.col) begin
        errors++;
        $error("column_index: expected %0d, actual %0d", want.col, got.col);
      end
      if (got.off != want.off) begin
        errors++;
        $error("field_offset: expected %0d, actual %0d", want.off, got.off);
      end
      if (got.len != want.len) begin
        errors++;
        $error("field_length: expected %0d, actual %0d", want.len, got.len);
      end
      if (got.last != want.last) begin
        errors++;
        $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  // Clock, reset and block ports; every input starts at a known value
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic in_end_of_file = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [ROW_W-1:0] out_row_index;
  logic [COL_W-1:0] out_column_index;
  logic [OFF_W-1:0] out_field_offset;
  logic [OFF_W-1:0] out_field_length;
  logic out_last_of_run;

  cell_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned files_sent = 0;
  int unsigned src_idle = 0;   // percent of cycles the sender holds off
  int unsigned dst_idle = 0;   // percent of cycles the receiver stalls
  logic [7:0] file_bytes[$];

  tsv_field_indexer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_field_offset (out_field_offset),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall out_ready at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle);
  end

  // Watch both handshakes at the rising edge. All block and testbench signals
  // but the clock change through nonblocking updates, so the values read here
  // are the ones the edge acted on. Enforce the cycle limit in the same place.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_end_of_file);
      if (out_valid && out_ready)
        sb.check_entry({out_row_index, out_column_index, out_field_offset,
                        out_field_length, out_last_of_run});
    end
  end

  // Offer one word and hold it until the block takes it. Idle gaps come first,
  // so valid never drops while a word is on offer.
  task automatic send_word(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every queued cell entry has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.cells_due.size() != 0) @(posedge clk);
  endtask

  // Any byte that is not a tab, CR or LF
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // Append one row of nf fields with up to max_len bytes each, then a line end
  function automatic void add_row(int nf, int max_len);
    int n;
    int r;
    for (int i = 0; i < nf; i++) begin
      if (i > 0) file_bytes.push_back(CHAR_TAB);
      n = $urandom_range(max_len);
      repeat (n) file_bytes.push_back(text_byte());
    end
    r = $urandom_range(9);
    if (r < 5) begin
      file_bytes.push_back(CHAR_LF);
    end else if (r < 8) begin
      file_bytes.push_back(CHAR_CR);
      file_bytes.push_back(CHAR_LF);
    end else begin
      file_bytes.push_back(CHAR_CR);
    end
  endfunction

  // Build one file: mostly well-formed tables with random content, some wide
  // or overflowing headers, occasional stray bytes and broken endings.
  function automatic void build_file();
    bit wide;
    int width;
    int rows;
    int nf;
    int r;
    int keep;
    file_bytes.delete();
    r = $urandom_range(19);
    wide = (r < 2);
    width = (r == 0) ? MAX_COLS : (r == 1) ? MAX_COLS + 1 + $urandom_range(2)
                                           : 1 + $urandom_range(5);
    rows = wide ? 1 : $urandom_range(4);
    add_row(width, wide ? 1 : 3);
    repeat (rows) begin
      if (wide) begin
        r = $urandom_range(3);
        nf = (r == 0) ? 1 : (r == 1) ? MAX_COLS : (r == 2) ? MAX_COLS + 2
                                                            : $urandom_range(1, MAX_COLS + 2);
      end else begin
        nf = $urandom_range(1, width + 2);
      end
      add_row(nf, wide ? 1 : 3);
    end
    // stray bytes of any value, terminators included
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 3))
        file_bytes.insert($urandom_range(file_bytes.size()), 8'($urandom_range(255)));
    // ending: keep the line end, drop it, end on a tab, or cut the file short
    r = $urandom_range(4);
    if (r == 2) begin
      void'(file_bytes.pop_back());
    end else if (r == 3) begin
      file_bytes.push_back(CHAR_TAB);
    end else if (r == 4) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    if (file_bytes.size() == 0) file_bytes.push_back(text_byte());
  endfunction

  // Send whole files until about n bytes have gone in
  task automatic run_random(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      build_file();
      foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
      sent += file_bytes.size();
      files_sent++;
    end
  endtask

  // Hand-picked files around the terminators, padding and end of file
  task automatic run_directed();
    // header of width 3 with all-ones and all-zeros field bytes, ended by CR LF
    send_word(8'hff, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_CR, 1'b0);
    send_word(CHAR_LF, 1'b0);
    // short row ended by CR LF: the pad entry points at the LF
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_CR, 1'b0);
    send_word(CHAR_LF, 1'b0);
    // empty row ended by a lone CR, then a text byte clears the pending CR
    send_word(CHAR_CR, 1'b0);
    send_word(8'h41, 1'b0);
    // too many fields: the fourth and later are dropped, no padding follows
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(8'h42, 1'b0);
    send_word(CHAR_LF, 1'b0);
    // end of file right after a tab: empty field plus padding
    send_word(8'h43, 1'b0);
    send_word(CHAR_TAB, 1'b1);
    // end of file on a final LF: nothing beyond the field it closes
    send_word(8'h44, 1'b0);
    send_word(CHAR_LF, 1'b1);
    // one-byte file: header only at end of file
    send_word(8'h45, 1'b1);
    // end of file on the LF of CR LF
    send_word(CHAR_CR, 1'b0);
    send_word(CHAR_LF, 1'b1);
    files_sent += 4;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender nearly always ready, receiver stalling half the time
    src_idle = 8;
    dst_idle = 51;
    run_directed();
    run_random(110);
    // pause the sender until the block has emptied
    hold_until_drained();

    // swap the roles
    src_idle = 51;
    dst_idle = 8;
    run_random(110);
    hold_until_drained();

    // full rate on both sides
    src_idle = 0;
    dst_idle = 0;
    run_random(110);

    hold_until_drained();
    repeat (20) @(posedge clk);

    $display("Indexed %0d bytes in %0d files, checked %0d cell entries, %0d errors",
             sb.bytes_seen, files_sent, sb.checked, sb.errors);
    $display("Included header overflow, short-row padding and end-of-file closing");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
